// ----- hdl/qpd_pkg.sv -----
`timescale 1ns / 1ps

package qpd_pkg;

  // Character codes the decoder looks for
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_DIG0 = 8'h30;
  localparam logic [7:0] CH_DIG9 = 8'h39;
  localparam logic [7:0] CH_HEXA = 8'h41;
  localparam logic [7:0] CH_HEXF = 8'h46;

  localparam int unsigned MaxRes = 3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_EQ     = 3'd1,
    PH_EQ_HEX = 3'd2,
    PH_EQ_CR  = 3'd3,
    PH_CR     = 3'd4
  } qpd_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } qpd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_done;
  } qpd_out_t;

  typedef struct packed {
    qpd_phase_e phase;
    logic [7:0] held;
    logic       stopped;
  } qpd_state_t;

  // Everything one input byte produces
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [MaxRes-1:0]      bvld;
    logic [1:0]             nres;
    logic                   done;
    qpd_state_t             nxt;
  } qpd_dec_t;

endpackage

// ----- hdl/qpd_decode.sv -----
`timescale 1ns / 1ps

module qpd_decode import qpd_pkg::*; (
  input  qpd_in_t    item_i,
  input  qpd_state_t st_i,
  output qpd_dec_t   dec_o
);

  localparam int unsigned NumCand = 5;

  // Candidate bytes in emission order: two held bytes flushed ahead of the
  // current byte, the current byte's own output, then two held bytes
  // flushed at the end of the message.
  logic [NumCand-1:0][7:0] cand;
  logic [NumCand-1:0]      cvld;
  logic [7:0]              c;
  logic                    last;
  logic                    c_hex;
  logic                    use_prefix;
  logic                    do_fresh;
  qpd_phase_e              ph_mid;
  logic [7:0]              held_mid;
  logic [2:0]              cnt;

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [3:0] v;
    if (ch inside {[CH_DIG0:CH_DIG9]}) v = ch[3:0];
    else v = ch[3:0] + 4'd9;
    return v;
  endfunction

  assign c     = item_i.in_byte;
  assign last  = item_i.end_of_input;
  assign c_hex = c inside {[CH_DIG0:CH_DIG9], [CH_HEXA:CH_HEXF]};

  always_comb begin
    cand       = '0;
    cvld       = '0;
    use_prefix = 1'b0;
    do_fresh   = 1'b0;
    ph_mid     = PH_IDLE;
    held_mid   = st_i.held;
    dec_o.nxt  = st_i;

    if (st_i.stopped) begin
      // Drop everything until the end mark
    end else if (c == CH_NUL) begin
      use_prefix        = 1'b1;
      held_mid          = '0;
      dec_o.nxt.stopped = !last;
    end else begin
      case (st_i.phase)
        PH_EQ: begin
          if (c_hex) begin
            ph_mid   = PH_EQ_HEX;
            held_mid = c;
          end else if (c == CH_CR) begin
            ph_mid = PH_EQ_CR;
          end else begin
            use_prefix = 1'b1;
            do_fresh   = 1'b1;
          end
        end
        PH_EQ_HEX: begin
          held_mid = '0;
          if (c_hex) begin
            cand[2] = {hex_val(st_i.held), hex_val(c)};
            cvld[2] = 1'b1;
          end else begin
            use_prefix = 1'b1;
            do_fresh   = 1'b1;
          end
        end
        PH_EQ_CR: begin
          if (c != CH_LF) begin
            use_prefix = 1'b1;
            do_fresh   = 1'b1;
          end
        end
        PH_CR: begin
          if (c == CH_LF) begin
            cand[2] = CH_LF;
            cvld[2] = 1'b1;
          end else begin
            use_prefix = 1'b1;
            do_fresh   = 1'b1;
          end
        end
        default: do_fresh = 1'b1;
      endcase
    end

    if (do_fresh) begin
      if (c == CH_EQ) begin
        ph_mid = PH_EQ;
      end else if (c == CH_CR) begin
        ph_mid = PH_CR;
      end else begin
        cand[2] = c;
        cvld[2] = 1'b1;
      end
    end

    // Flush of the phase held before this byte
    if (use_prefix) begin
      case (st_i.phase)
        PH_EQ: begin
          cand[0] = CH_EQ;  cvld[0] = 1'b1;
        end
        PH_EQ_HEX: begin
          cand[0] = CH_EQ;  cvld[0] = 1'b1;
          cand[1] = st_i.held; cvld[1] = 1'b1;
        end
        PH_EQ_CR: begin
          cand[0] = CH_EQ;  cvld[0] = 1'b1;
          cand[1] = CH_CR;  cvld[1] = 1'b1;
        end
        PH_CR: begin
          cand[0] = CH_CR;  cvld[0] = 1'b1;
        end
        default: ;
      endcase
    end

    dec_o.nxt.phase = ph_mid;
    dec_o.nxt.held  = held_mid;

    // End of message: flush what is still held and return to reset
    if (last) begin
      case (ph_mid)
        PH_EQ: begin
          cand[3] = CH_EQ;  cvld[3] = 1'b1;
        end
        PH_EQ_HEX: begin
          cand[3] = CH_EQ;  cvld[3] = 1'b1;
          cand[4] = held_mid; cvld[4] = 1'b1;
        end
        PH_EQ_CR: begin
          cand[3] = CH_EQ;  cvld[3] = 1'b1;
          cand[4] = CH_CR;  cvld[4] = 1'b1;
        end
        PH_CR: begin
          cand[3] = CH_CR;  cvld[3] = 1'b1;
        end
        default: ;
      endcase
      dec_o.nxt = '{phase: PH_IDLE, held: '0, stopped: 1'b0};
    end

    // Pack candidates into result slots, at most three
    dec_o.bytes = '0;
    dec_o.bvld  = '0;
    cnt         = '0;
    for (int i = 0; i < NumCand; i++) begin
      if (cvld[i] && cnt < 3'(MaxRes)) begin
        dec_o.bytes[cnt[1:0]] = cand[i];
        dec_o.bvld[cnt[1:0]]  = 1'b1;
        cnt                   = cnt + 3'd1;
      end
    end
    // An end mark with no byte rides on one empty result
    if (cnt == 3'd0 && last) dec_o.nres = 2'd1;
    else dec_o.nres = cnt[1:0];
    dec_o.done = last;
  end

endmodule

// ----- hdl/quoted_printable_decoder.sv -----
`timescale 1ns / 1ps

// Quoted-printable decoder.
// Input channel: one encoded character per transfer (in_data_i), with
// end_of_input marking the final character of a message. Output channel:
// one result per transfer (out_data_o) carrying a decoded byte or, for the
// end mark alone, an empty result with byte_valid low.
// Each input transfer yields zero to three results; run_last flags the
// last result of that input and message_done the last of the message.
// Path: an input passes through the input register and is then decoded
// into the result register, from which its first result is offered.
// Throughput: one input per cycle while each input gives at most one
// result and out_ready_i stays high; an input giving k results holds
// the single result register until its k slots drain, one per transfer.
// Inputs dropped after a NUL, and soft line breaks, load no result.
// Stall: while out_ready_i is low the result holds and, once the input
// register is also full, in_ready_o drops; nothing is lost.
// Reset: asynchronous, active low; clears both registers' valid flags and
// the decoder state (nothing held, no NUL seen).

module quoted_printable_decoder import qpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  qpd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output qpd_out_t out_data_o
);

  // Input register
  logic    in_vld_q;
  qpd_in_t in_q;

  // Result register: up to three slots, drained one per transfer
  logic                   out_vld_q;
  logic [MaxRes-1:0][7:0] bytes_q;
  logic [MaxRes-1:0]      bvld_q;
  logic [1:0]             nres_q;
  logic [1:0]             idx_q;
  logic                   done_q;

  qpd_state_t st_q;
  qpd_dec_t   dec;

  logic last_slot;
  logic out_pop;
  logic out_free;
  logic take;

  qpd_decode u_decode (
    .item_i (in_q),
    .st_i   (st_q),
    .dec_o  (dec)
  );

  assign last_slot = (idx_q == nres_q - 2'd1);
  assign out_pop   = out_valid_o && out_ready_i;
  // Result register frees up when empty or when its last slot leaves now
  assign out_free  = !out_vld_q || (out_ready_i && last_slot);
  assign take      = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || take;

  assign out_valid_o             = out_vld_q;
  assign out_data_o.out_byte     = bytes_q[idx_q];
  assign out_data_o.byte_valid   = bvld_q[idx_q];
  assign out_data_o.run_last     = last_slot;
  assign out_data_o.message_done = done_q && last_slot;

  // Hold an accepted input until the decoder takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  // Advance decoder state once per decoded input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, held: '0, stopped: 1'b0};
    end else if (take) begin
      st_q <= dec.nxt;
    end
  end

  // Load results, or advance through the slots one transfer at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (take && dec.nres != 2'd0) begin
      out_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (out_pop) begin
      if (last_slot) out_vld_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && dec.nres != 2'd0) begin
      bytes_q <= dec.bytes;
      bvld_q  <= dec.bvld;
      nres_q  <= dec.nres;
      done_q  <= dec.done;
    end
  end

endmodule

// ----- hdl/qpd_checker.sv -----
`timescale 1ns / 1ps

module qpd_checker import qpd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input qpd_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input qpd_out_t out_data_o
);

  // A waiting input holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("waiting input changed");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The message end is always the last result of its input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.message_done |-> out_data_o.run_last)
    else $error("message_done without run_last");

  // An empty result only carries the end mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.message_done)
    else $error("empty result without end mark");

  // An empty result carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.out_byte == 8'h00)
    else $error("empty result with nonzero byte");

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- test/quoted_printable_decoder_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the quoted-printable decoder: a clocked driver
// feeds encoded characters from a queue, a clocked monitor checks every
// decoded result against a cycle-free prediction of the decoder.

module quoted_printable_decoder_tb;
  import qpd_pkg::*;

  localparam int unsigned ResetCycles = 5;
  localparam int unsigned RandomChars = 400;
  localparam int unsigned IdleLimit   = 2000;  // cycles with no transfer at all
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldoffAt   = 150;   // characters in before the long stall
  localparam int unsigned HoldoffLen  = 300;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  qpd_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  qpd_out_t out_data_o;

  quoted_printable_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Characters still to send, and decoded results still due from the block
  qpd_in_t  encoded_chars[$];
  qpd_out_t decoded_due[$];

  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned chars_accepted = 0;

  // ------------------------------------------------------------------
  // Decoder prediction: its own copy of the decoder state, advanced once
  // per accepted character; the results of one step collect in step_res.
  // ------------------------------------------------------------------
  qpd_phase_e  dec_phase   = PH_IDLE;
  logic [7:0]  dec_held    = '0;
  logic        dec_stopped = 1'b0;
  qpd_out_t    step_res [MaxRes];
  int unsigned step_cnt;

  // Append one result; like the block, a fourth result in one step is lost.
  function automatic void emit_char(input logic [7:0] b, input logic vld);
    if (step_cnt < MaxRes) begin
      step_res[step_cnt].out_byte     = b;
      step_res[step_cnt].byte_valid   = vld;
      step_res[step_cnt].run_last     = 1'b0;
      step_res[step_cnt].message_done = 1'b0;
      step_cnt++;
    end
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] c);
    return (c >= CH_DIG0 && c <= CH_DIG9) || (c >= CH_HEXA && c <= CH_HEXF);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = (c <= CH_DIG9) ? c - CH_DIG0 : c - CH_HEXA + 8'd10;
    return v[3:0];
  endfunction

  // A character seen with nothing held: start a hold or pass it through.
  function automatic void take_fresh(input logic [7:0] c);
    if (c == CH_EQ) dec_phase = PH_EQ;
    else if (c == CH_CR) dec_phase = PH_CR;
    else emit_char(c, 1'b1);
  endfunction

  // Give back whatever is held as literal bytes and drop the hold.
  function automatic void flush_held();
    case (dec_phase)
      PH_EQ: begin
        emit_char(CH_EQ, 1'b1);
      end
      PH_EQ_HEX: begin
        emit_char(CH_EQ, 1'b1);
        emit_char(dec_held, 1'b1);
      end
      PH_EQ_CR: begin
        emit_char(CH_EQ, 1'b1);
        emit_char(CH_CR, 1'b1);
      end
      PH_CR: begin
        emit_char(CH_CR, 1'b1);
      end
      default: ;
    endcase
    dec_phase = PH_IDLE;
    dec_held  = '0;
  endfunction

  // Advance the prediction by one accepted character; queue its results.
  function automatic void decode_char(input qpd_in_t item);
    logic [7:0] c;
    logic       last;
    qpd_phase_e ph;
    c        = item.in_byte;
    last     = item.end_of_input;
    step_cnt = 0;

    if (dec_stopped) begin
      // after a NUL only the end mark produces anything
      if (last) emit_char(CH_NUL, 1'b0);
    end else if (c == CH_NUL) begin
      flush_held();
      if (!last) dec_stopped = 1'b1;
    end else begin
      ph        = dec_phase;
      dec_phase = PH_IDLE;
      case (ph)
        PH_EQ: begin
          if (is_upper_hex(c)) begin
            dec_held  = c;
            dec_phase = PH_EQ_HEX;
          end else if (c == CH_CR) begin
            dec_phase = PH_EQ_CR;
          end else begin
            emit_char(CH_EQ, 1'b1);
            take_fresh(c);
          end
        end
        PH_EQ_HEX: begin
          if (is_upper_hex(c)) begin
            emit_char({hex_nibble(dec_held), hex_nibble(c)}, 1'b1);
          end else begin
            emit_char(CH_EQ, 1'b1);
            emit_char(dec_held, 1'b1);
            take_fresh(c);
          end
          dec_held = '0;
        end
        PH_EQ_CR: begin
          // '=' CR LF is a soft break and yields nothing
          if (c != CH_LF) begin
            emit_char(CH_EQ, 1'b1);
            emit_char(CH_CR, 1'b1);
            take_fresh(c);
          end
        end
        PH_CR: begin
          if (c == CH_LF) begin
            emit_char(CH_LF, 1'b1);
          end else begin
            emit_char(CH_CR, 1'b1);
            take_fresh(c);
          end
        end
        default: begin
          take_fresh(c);
        end
      endcase
    end

    if (last) begin
      flush_held();
      if (step_cnt == 0) emit_char(CH_NUL, 1'b0);
      step_res[step_cnt-1].message_done = 1'b1;
      dec_phase   = PH_IDLE;
      dec_held    = '0;
      dec_stopped = 1'b0;
    end
    if (step_cnt > 0) step_res[step_cnt-1].run_last = 1'b1;
    for (int unsigned i = 0; i < step_cnt; i++) decoded_due.push_back(step_res[i]);
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  // While quiet is counting down, no idling at all.
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_char(input logic [7:0] b, input logic last);
    qpd_in_t item;
    item.in_byte      = b;
    item.end_of_input = last;
    encoded_chars.push_back(item);
  endfunction

  // ------------------------------------------------------------------
  // Driver: present the next character, hold it until the transfer,
  // then idle for a random gap before the next one.
  // ------------------------------------------------------------------
  int unsigned send_gap   = 0;
  int unsigned send_quiet = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_char(in_data_i);
        chars_accepted++;
      end
      // the slot is free unless a character is still waiting for ready
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (encoded_chars.size() > 0) begin
          in_data_i  <= encoded_chars.pop_front();
          in_valid_i <= 1'b1;
          send_gap   = pick_gap(send_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off while the
  // driver keeps offering, so the block fills and drops in_ready_o.
  // ------------------------------------------------------------------
  int unsigned stall_left   = 0;
  int unsigned ready_quiet  = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (!holdoff_done && chars_accepted >= HoldoffAt) begin
        holdoff_left = HoldoffLen;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left  = pick_gap(ready_quiet);
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest one due, and
  // count cycles in which neither channel moves for the watchdog.
  // ------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    qpd_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
          mismatches++;
        end else begin
          want = decoded_due.pop_front();
          check_field("out_byte", want.out_byte, out_data_o.out_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_data_o.byte_valid));
          check_field("run_last", 8'(want.run_last), 8'(out_data_o.run_last));
          check_field("message_done", 8'(want.message_done), 8'(out_data_o.message_done));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ------------------------------------------------------------------
  initial begin
    logic [7:0]  msg[$];
    int unsigned target;
    int unsigned r;
    logic [7:0]  b;

    // Directed: literal extremes and every escape form
    add_char(8'hFF, 1'b0);                                      // high literal
    add_char(CH_EQ, 1'b0); add_char("F", 1'b0); add_char("F", 1'b0);  // -> FF
    add_char(CH_EQ, 1'b0); add_char("0", 1'b0); add_char("0", 1'b0);  // -> 00
    add_char(CH_EQ, 1'b0); add_char(CH_CR, 1'b0); add_char(CH_LF, 1'b0); // soft break
    add_char(CH_CR, 1'b0); add_char(CH_LF, 1'b0);               // CR LF -> LF
    add_char(CH_EQ, 1'b0); add_char("a", 1'b0);                 // lowercase: literal
    add_char(CH_EQ, 1'b0); add_char("4", 1'b0); add_char("g", 1'b0); // broken escape
    add_char(CH_EQ, 1'b0); add_char(CH_CR, 1'b0); add_char("x", 1'b0); // broken soft break
    // stray CR, then an end that fills all three result slots
    add_char(CH_CR, 1'b0); add_char(CH_EQ, 1'b0); add_char("A", 1'b0);
    add_char(CH_EQ, 1'b1);
    // NUL after '=' flushes it, then input is dropped until the end mark
    add_char(CH_EQ, 1'b0); add_char(CH_NUL, 1'b0); add_char("q", 1'b0);
    add_char("z", 1'b1);
    add_char(CH_NUL, 1'b1);                                     // NUL that is the end

    // Random messages, mostly well-formed with some noise mixed in
    target = encoded_chars.size() + RandomChars;
    while (encoded_chars.size() < target) begin
      msg.delete();
      r = $urandom_range(1, 24);
      while (msg.size() < r) begin
        case ($urandom_range(0, 99)) inside
          [0:39]: begin
            do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CH_EQ);
            msg.push_back(b);
          end
          [40:54]: begin
            msg.push_back(CH_EQ);
            repeat (2) begin
              b = 8'($urandom_range(0, 15));
              msg.push_back(b < 10 ? CH_DIG0 + b : CH_HEXA + b - 8'd10);
            end
          end
          [55:61]: begin
            msg.push_back(CH_EQ); msg.push_back(CH_CR); msg.push_back(CH_LF);
          end
          [62:71]: begin
            msg.push_back(CH_CR); msg.push_back(CH_LF);
          end
          [72:79]: begin
            msg.push_back(CH_EQ);
            msg.push_back(8'("a" + $urandom_range(0, 5)));
            msg.push_back(CH_DIG0 + 8'($urandom_range(0, 9)));
          end
          [80:89]: msg.push_back(8'($urandom_range(1, 255)));
          [90:93]: msg.push_back($urandom_range(0, 1) ? CH_EQ : CH_CR);
          [94:95]: msg.push_back(CH_NUL);
          default: msg.push_back(8'($urandom_range(8'h80, 8'hFF)));
        endcase
      end
      foreach (msg[i]) add_char(msg[i], i == msg.size() - 1);
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run until every character went in and every result came out
    while ((encoded_chars.size() != 0 || in_valid_i || decoded_due.size() != 0) &&
           idle_cycles < IdleLimit)
      @(negedge clk_i);

    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, %0d results still due", $time, decoded_due.size());
      $display("Simulation FAILED");
    end else begin
      // let any trailing result show up before judging
      repeat (DrainCycles) @(posedge clk_i);
      if (mismatches == 0 && decoded_due.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

endmodule
